// ===== src/qstg_pkg.sv =====
// Shared types, constants and the sine table for the queued sine tone generator.
`default_nettype none

package qstg_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int USED_W      = $clog2(QUEUE_DEPTH + 1);

    // Sine table geometry (power of two, stored as one quarter wave)
    localparam int SINE_TABLE_SIZE = 1024;
    localparam int SINE_BITS       = $clog2(SINE_TABLE_SIZE);
    localparam int QUARTER_SIZE    = SINE_TABLE_SIZE / 4;
    localparam int QUARTER_BITS    = SINE_BITS - 2;

    // Field widths
    localparam int OP_W     = 2;
    localparam int RATE_W   = 16;
    localparam int FREQ_W   = 15;
    localparam int AMP_W    = 15;
    localparam int DUR_W    = 16;
    localparam int SAMPLE_W = 16;
    localparam int COUNT_W  = 5;
    localparam int LEFT_W   = 22;
    localparam int ENTRY_W  = 16;

    localparam logic [RATE_W-1:0] RATE_RESET = 16'd44100;

    // Duration to sample count: (ms * rate) / 1000 by reciprocal multiply
    localparam int PROD1_W     = DUR_W + RATE_W;
    localparam int RECIP_W     = 29;
    localparam logic [RECIP_W-1:0] RECIP_MAGIC = 29'h10624DD3;
    localparam int RECIP_SHIFT = 38;
    localparam int PROD2_W     = PROD1_W + RECIP_W;
    localparam int COUNT_RAW_W = PROD2_W - RECIP_SHIFT;

    // Shared divider: remainder ops use a 17-bit dividend, the index op a wide one
    localparam int MOD_W  = RATE_W + 1;
    localparam int DIV_W  = RATE_W + SINE_BITS;
    localparam int STEP_W = $clog2(DIV_W + 1);

    // Amplitude scaling
    localparam int MAG_PROD_W = AMP_W + ENTRY_W;
    localparam int MAG_SHIFT  = 15;

    // Q30 polynomial coefficients for sin(pi/2 * x)
    localparam longint unsigned K1  = 64'd1686629713;
    localparam longint unsigned K3  = 64'd693598670;
    localparam longint unsigned K5  = 64'd85569306;
    localparam longint unsigned K7  = 64'd5026995;
    localparam longint unsigned K9  = 64'd172272;
    localparam longint unsigned K11 = 64'd3864;

    typedef enum logic [OP_W-1:0] {
        OP_ENQUEUE = 2'd0,
        OP_SAMPLE  = 2'd1,
        OP_CLEAR   = 2'd2
    } op_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [FREQ_W-1:0] tone_frequency;
        logic [AMP_W-1:0]  tone_amplitude;
        logic [DUR_W-1:0]  duration_ms;
    } item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       sample_valid;
        logic                       queue_drop;
        logic [COUNT_W-1:0]         queue_count;
    } result_t;

    typedef struct packed {
        logic [FREQ_W-1:0] frequency;
        logic [AMP_W-1:0]  amplitude;
        logic [LEFT_W-1:0] remaining;
    } tone_t;

    typedef enum logic [1:0] {
        DIV_WRAP_ACC,
        DIV_INDEX,
        DIV_WRAP_NEXT
    } div_sel_t;

    typedef struct packed {
        logic             load_item;
        logic             mul_duration;
        logic             mul_recip;
        logic             push;
        logic             clear;
        logic             check;
        logic             div_start;
        div_sel_t         div_sel;
        logic             take_phase;
        logic             take_index;
        logic             take_acc;
        logic             rom_read;
        logic             amp_mul;
        logic             countdown;
        logic             result_load;
    } dp_cmd_t;

    typedef struct packed {
        logic queue_empty;
        logic rate_zero;
        logic div_done;
    } dp_status_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [STEP_W-1:0] steps;
    } div_cmd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ENQ_MUL,
        S_ENQ_RECIP,
        S_ENQ_PUSH,
        S_CLEAR,
        S_SMP_CHECK,
        S_SMP_MOD,
        S_SMP_IDX_GO,
        S_SMP_IDX,
        S_SMP_WRAP_GO,
        S_SMP_WRAP,
        S_SMP_ROM,
        S_SMP_MUL,
        S_SMP_END,
        S_FINISH
    } state_t;

    typedef logic [ENTRY_W-1:0] quarter_rom_t [QUARTER_SIZE];

    // Odd polynomial of degree 11 in Horner form, every product truncated to Q30.
    function automatic longint unsigned quarter_sine_q30(input longint unsigned x);
        longint unsigned x2;
        longint unsigned p;
        x2 = (x * x) >> 30;
        p  = K11;
        p  = K9 - ((x2 * p) >> 30);
        p  = K7 - ((x2 * p) >> 30);
        p  = K5 - ((x2 * p) >> 30);
        p  = K3 - ((x2 * p) >> 30);
        p  = K1 - ((x2 * p) >> 30);
        return (x * p) >> 30;
    endfunction

    // Q15 sine magnitude at quarter-wave position m (0 up to QUARTER_SIZE).
    function automatic logic [ENTRY_W-1:0] quarter_value(input int unsigned m);
        longint unsigned x;
        longint unsigned s;
        x = (64'(m) << 32) / SINE_TABLE_SIZE;
        s = (quarter_sine_q30(x) + 64'd16384) >> 15;
        return ENTRY_W'(s);
    endfunction

    function automatic quarter_rom_t build_quarter_rom();
        quarter_rom_t rom;
        int unsigned  i;
        for (i = 0; i < QUARTER_SIZE; i++) begin
            rom[i] = quarter_value(i);
        end
        return rom;
    endfunction

    localparam quarter_rom_t QUARTER_ROM = build_quarter_rom();
    localparam logic [ENTRY_W-1:0] SINE_PEAK = quarter_value(QUARTER_SIZE);

endpackage

`default_nettype wire

// ===== src/qstg_divider.sv =====
// Bit-serial restoring divider shared by the phase wrap and table index steps.
`default_nettype none

module qstg_divider
    import qstg_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire div_cmd_t          cmd,
    input  wire logic [RATE_W-1:0] divisor,
    output logic                   done,
    output logic [DIV_W-1:0]       quotient,
    output logic [RATE_W-1:0]      remainder
);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] count_reg;
    logic [DIV_W-1:0]  quo_reg;
    logic [RATE_W-1:0] rem_reg;

    logic [RATE_W:0]   shifted;
    logic [RATE_W+1:0] diff;
    logic              ge;
    logic [RATE_W-1:0] rem_next;

    // One quotient bit per cycle: shift in the next dividend bit and try a subtract.
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[DIV_W-1]};
        diff     = {1'b0, shifted} - {2'b00, divisor};
        ge       = ~diff[RATE_W+1];
        rem_next = ge ? diff[RATE_W-1:0] : shifted[RATE_W-1:0];
    end

    // Iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= cmd.steps;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - 1'b1;
                if (count_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Partial remainder and quotient shift register
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            quo_reg <= cmd.dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ===== src/qstg_datapath.sv =====
// Datapath: rate register, tone queue, phase accumulator, sine lookup and scaling.
`default_nettype none

module qstg_datapath
    import qstg_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_write,
    input  wire logic [RATE_W-1:0] cfg_data,
    input  wire item_t             item,
    input  wire dp_cmd_t           cmd,
    output dp_status_t             status,
    output result_t                result
);

    localparam logic [USED_W-1:0] USED_FULL = USED_W'(QUEUE_DEPTH);

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] i);
        logic [PTR_W-1:0] n;
        if (i == PTR_W'(QUEUE_DEPTH - 1))
        begin
            n = '0;
        end
        else
        begin
            n = i + 1'b1;
        end
        return n;
    endfunction

    logic [RATE_W-1:0]          rate_reg;
    item_t                      item_reg;
    logic [PROD1_W-1:0]         prod1_reg;
    logic [PROD2_W-1:0]         prod2_reg;

    tone_t                      mem [QUEUE_DEPTH];
    tone_t                      rd_reg;
    logic [PTR_W-1:0]           head_reg, head_next;
    logic [PTR_W-1:0]           tail_reg, tail_next;
    logic [USED_W-1:0]          used_reg, used_next;

    logic [RATE_W-1:0]          phase_acc_reg;
    logic [RATE_W-1:0]          phase_reg;
    logic [SINE_BITS-1:0]       index_reg;
    logic [ENTRY_W-1:0]         entry_mag_reg;
    logic                       entry_neg_reg;
    logic [MAG_PROD_W-1:0]      mag_prod_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                       smp_valid_reg;
    logic                       drop_reg;
    result_t                    result_reg;

    logic [COUNT_RAW_W-1:0]     count_raw;
    logic [LEFT_W-1:0]          count_sat;
    logic                       count_zero;
    logic                       queue_full;
    logic                       queue_empty;
    logic                       push_write;
    logic [LEFT_W-1:0]          left;
    logic                       pop;
    logic                       wr_en;
    logic [PTR_W-1:0]           wr_addr;
    tone_t                      wr_data;

    div_cmd_t                   div_cmd;
    logic                       div_done;
    logic [DIV_W-1:0]           div_quotient;
    logic [RATE_W-1:0]          div_remainder;
    logic [MOD_W-1:0]           phase_sum;

    logic                       rom_odd;
    logic [QUARTER_BITS-1:0]    rom_low;
    logic [QUARTER_BITS-1:0]    rom_mirror;
    logic [ENTRY_W-1:0]         rom_value;
    logic [SAMPLE_W-1:0]        mag;

    // Sample count for an enqueue, saturated to the counter width
    always_comb
    begin
        count_raw  = prod2_reg[PROD2_W-1:RECIP_SHIFT];
        count_sat  = (|count_raw[COUNT_RAW_W-1:LEFT_W]) ? '1 : count_raw[LEFT_W-1:0];
        count_zero = (count_sat == '0);
    end

    // Queue flags and the writes that the current command causes
    always_comb
    begin
        queue_full  = (used_reg == USED_FULL);
        queue_empty = (used_reg == '0);
        push_write  = cmd.push && !count_zero && !queue_full;
        left        = rd_reg.remaining - 1'b1;
        pop         = cmd.countdown && (left == '0);
        wr_en       = push_write || (cmd.countdown && !pop);
        wr_addr     = cmd.push ? tail_reg : head_reg;
        if (cmd.push)
        begin
            wr_data.frequency = item_reg.tone_frequency;
            wr_data.amplitude = item_reg.tone_amplitude;
            wr_data.remaining = count_sat;
        end
        else
        begin
            wr_data.frequency = rd_reg.frequency;
            wr_data.amplitude = rd_reg.amplitude;
            wr_data.remaining = left;
        end
    end

    // Pointer and fill count updates
    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        used_next = used_reg;
        if (cmd.clear)
        begin
            head_next = '0;
            tail_next = '0;
            used_next = '0;
        end
        else if (push_write)
        begin
            tail_next = next_slot(tail_reg);
            used_next = used_reg + 1'b1;
        end
        else if (pop)
        begin
            head_next = next_slot(head_reg);
            used_next = used_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            used_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            used_reg <= used_next;
        end
    end

    // Tone queue memory with a registered read of the head entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg <= mem[head_reg];
    end

    // Sample rate register and phase accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg      <= RATE_RESET;
            phase_acc_reg <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                rate_reg <= cfg_data;
            end
            if (cmd.check && !queue_empty && (rate_reg == '0))
            begin
                phase_acc_reg <= '0;
            end
            else if (cmd.take_acc)
            begin
                phase_acc_reg <= div_remainder;
            end
        end
    end

    // Divider operand selection; remainder ops left-align a short dividend
    always_comb
    begin
        phase_sum        = MOD_W'(phase_reg) + MOD_W'(rd_reg.frequency);
        div_cmd.start    = cmd.div_start;
        unique case (cmd.div_sel)
            DIV_INDEX:
            begin
                div_cmd.dividend = {phase_reg, {SINE_BITS{1'b0}}};
                div_cmd.steps    = STEP_W'(DIV_W);
            end
            DIV_WRAP_NEXT:
            begin
                div_cmd.dividend = {phase_sum, {(DIV_W - MOD_W){1'b0}}};
                div_cmd.steps    = STEP_W'(MOD_W);
            end
            default:
            begin
                div_cmd.dividend = {1'b0, phase_acc_reg, {(DIV_W - MOD_W){1'b0}}};
                div_cmd.steps    = STEP_W'(MOD_W);
            end
        endcase
    end

    qstg_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (div_cmd),
        .divisor   (rate_reg),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    // Quarter-wave lookup: mirror in odd quadrants, sign from the upper half
    always_comb
    begin
        rom_odd    = index_reg[SINE_BITS-2];
        rom_low    = index_reg[QUARTER_BITS-1:0];
        rom_mirror = '0 - rom_low;
        if (rom_odd && (rom_low == '0))
        begin
            rom_value = SINE_PEAK;
        end
        else
        begin
            rom_value = QUARTER_ROM[rom_odd ? rom_mirror : rom_low];
        end
        mag = mag_prod_reg[MAG_PROD_W-1:MAG_SHIFT];
    end

    // Item, enqueue arithmetic and sample pipeline registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg      <= item;
            sample_reg    <= '0;
            smp_valid_reg <= 1'b0;
            drop_reg      <= 1'b0;
        end
        if (cmd.mul_duration)
        begin
            prod1_reg <= PROD1_W'(item_reg.duration_ms) * PROD1_W'(rate_reg);
        end
        if (cmd.mul_recip)
        begin
            prod2_reg <= PROD2_W'(prod1_reg) * PROD2_W'(RECIP_MAGIC);
        end
        if (cmd.push)
        begin
            drop_reg <= !count_zero && queue_full;
        end
        if (cmd.check)
        begin
            smp_valid_reg <= !queue_empty;
            entry_mag_reg <= '0;
            entry_neg_reg <= 1'b0;
        end
        if (cmd.take_phase)
        begin
            phase_reg <= div_remainder;
        end
        if (cmd.take_index)
        begin
            index_reg <= (|div_quotient[DIV_W-1:SINE_BITS]) ? '1
                                                            : div_quotient[SINE_BITS-1:0];
        end
        if (cmd.rom_read)
        begin
            entry_mag_reg <= rom_value;
            entry_neg_reg <= index_reg[SINE_BITS-1];
        end
        if (cmd.amp_mul)
        begin
            mag_prod_reg <= MAG_PROD_W'(rd_reg.amplitude) * MAG_PROD_W'(entry_mag_reg);
        end
        if (cmd.countdown)
        begin
            sample_reg <= $signed(entry_neg_reg ? ('0 - mag) : mag);
        end
        if (cmd.result_load)
        begin
            result_reg.sample       <= sample_reg;
            result_reg.sample_valid <= smp_valid_reg;
            result_reg.queue_drop   <= drop_reg;
            result_reg.queue_count  <= COUNT_W'(used_reg);
        end
    end

    assign status.queue_empty = queue_empty;
    assign status.rate_zero   = (rate_reg == '0);
    assign status.div_done    = div_done;
    assign result             = result_reg;

`ifndef SYNTHESIS
    // An empty or a full queue has its pointers on the same slot.
    a_ptr_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (used_reg == '0 || used_reg == USED_FULL) |-> head_reg == tail_reg)
        else $error("queue pointers disagree with fill count");

    // A wrapped phase lands below the sample rate.
    a_phase_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take_acc |=> phase_acc_reg < rate_reg)
        else $error("phase accumulator not below sample rate");

    // A push into a full queue leaves the tail where it was.
    a_full_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.push && queue_full) |=> $stable(tail_reg) && used_reg == USED_FULL)
        else $error("tone written into a full queue");
`endif

endmodule

`default_nettype wire

// ===== src/qstg_ctrl.sv =====
// Controller state machine that sequences the datapath for each input beat.
`default_nettype none

module qstg_ctrl
    import qstg_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    input  wire logic [OP_W-1:0] item_op,
    output logic                 item_stall,
    output logic                 result_valid,
    input  wire logic            result_stall,
    input  wire dp_status_t      status,
    output dp_cmd_t              cmd
);

    state_t state_reg, state_next;
    logic   result_valid_reg, result_valid_next;
    logic   out_free;

    assign out_free = !result_valid_reg || !result_stall;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    unique case (item_op)
                        OP_ENQUEUE: state_next = S_ENQ_MUL;
                        OP_SAMPLE:  state_next = S_SMP_CHECK;
                        OP_CLEAR:   state_next = S_CLEAR;
                        default:    state_next = S_FINISH;
                    endcase
                end
            end
            S_ENQ_MUL:   state_next = S_ENQ_RECIP;
            S_ENQ_RECIP: state_next = S_ENQ_PUSH;
            S_ENQ_PUSH:  state_next = S_FINISH;
            S_CLEAR:     state_next = S_FINISH;
            S_SMP_CHECK:
            begin
                priority if (status.queue_empty)
                begin
                    state_next = S_FINISH;
                end
                else if (status.rate_zero)
                begin
                    state_next = S_SMP_MUL;
                end
                else
                begin
                    state_next = S_SMP_MOD;
                end
            end
            S_SMP_MOD:
            begin
                if (status.div_done)
                begin
                    state_next = S_SMP_IDX_GO;
                end
            end
            S_SMP_IDX_GO: state_next = S_SMP_IDX;
            S_SMP_IDX:
            begin
                if (status.div_done)
                begin
                    state_next = S_SMP_WRAP_GO;
                end
            end
            S_SMP_WRAP_GO: state_next = S_SMP_WRAP;
            S_SMP_WRAP:
            begin
                if (status.div_done)
                begin
                    state_next = S_SMP_ROM;
                end
            end
            S_SMP_ROM: state_next = S_SMP_MUL;
            S_SMP_MUL: state_next = S_SMP_END;
            S_SMP_END: state_next = S_FINISH;
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath commands
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:       cmd.load_item    = item_valid;
            S_ENQ_MUL:    cmd.mul_duration = 1'b1;
            S_ENQ_RECIP:  cmd.mul_recip    = 1'b1;
            S_ENQ_PUSH:   cmd.push         = 1'b1;
            S_CLEAR:      cmd.clear        = 1'b1;
            S_SMP_CHECK:
            begin
                cmd.check     = 1'b1;
                cmd.div_start = !status.queue_empty && !status.rate_zero;
                cmd.div_sel   = DIV_WRAP_ACC;
            end
            S_SMP_MOD:    cmd.take_phase   = status.div_done;
            S_SMP_IDX_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_INDEX;
            end
            S_SMP_IDX:    cmd.take_index   = status.div_done;
            S_SMP_WRAP_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_WRAP_NEXT;
            end
            S_SMP_WRAP:   cmd.take_acc     = status.div_done;
            S_SMP_ROM:    cmd.rom_read     = 1'b1;
            S_SMP_MUL:    cmd.amp_mul      = 1'b1;
            S_SMP_END:    cmd.countdown    = 1'b1;
            S_FINISH:     cmd.result_load  = out_free;
            default:      cmd              = '0;
        endcase
    end

    // Output register occupancy: set on load, cleared when the beat is taken
    always_comb
    begin
        priority if (cmd.result_load)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;

`ifndef SYNTHESIS
    // A finished result waits while the previous beat is still held by the consumer.
    a_finish_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && result_valid_reg && result_stall)
        |=> state_reg == S_FINISH)
        else $error("result register overwritten while stalled");
`endif

endmodule

`default_nettype wire

// ===== src/queued_sine_tone_generator_core.sv =====
// Top level of the queued sine tone generator.
//
// Tones (frequency in Hz, amplitude, duration in ms) are queued in a
// sixteen-entry FIFO; each sample request plays the head tone through a
// quarter-wave sine table, advances the phase by the frequency modulo the
// sample rate and pops the tone when its sample count runs out. Both channels
// move one beat per handshake on valid and stall; the sample rate register is
// written with cfg_write, and the user must write it only while the block is
// idle, which the block itself does not enforce. Every input beat yields
// exactly one result beat, and a new beat is taken as soon as the previous
// one has been handed to the output register. An enqueue runs two registered
// multiplies that turn the duration into a sample count. With a nonzero rate
// and a tone queued, a sample request runs the bit-serial divider three times:
// 17 steps to wrap the phase, 26 for the table index, 17 for the next phase.
`default_nettype none

module queued_sine_tone_generator_core
    import qstg_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_write,
    input  wire logic [RATE_W-1:0] cfg_data,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire item_t             item,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output result_t                result
);

    dp_cmd_t    cmd;
    dp_status_t status;

    qstg_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_op      (item.op),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    qstg_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .item      (item),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

endmodule

`default_nettype wire

// ===== verif/tb_queued_sine_tone_generator_core.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the queued sine tone generator core.
module tb_queued_sine_tone_generator_core;
    import qstg_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 4;
    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_LIMIT    = 4000;
    localparam int LONG_HOLD     = 400;
    localparam int IDLE_MAX      = 8;

    localparam longint unsigned MS_PER_SEC = 64'd1000;
    localparam longint unsigned COUNT_CEIL = 64'd4194303;
    localparam longint unsigned Q30_UNIT   = 64'd1073741824;

    // Q30 coefficients of the odd polynomial for sin(pi/2 * x).
    localparam longint unsigned C1  = 64'd1686629713;
    localparam longint unsigned C3  = 64'd693598670;
    localparam longint unsigned C5  = 64'd85569306;
    localparam longint unsigned C7  = 64'd5026995;
    localparam longint unsigned C9  = 64'd172272;
    localparam longint unsigned C11 = 64'd3864;

    logic              clk;
    logic              rst_n;
    logic              cfg_write;
    logic [RATE_W-1:0] cfg_data;
    logic              item_valid;
    logic              item_stall;
    item_t             item;
    logic              result_valid;
    logic              result_stall;
    result_t           result;

    // Mirror of the block's state.
    int          sine_lut [SINE_TABLE_SIZE];
    tone_t       tone_fifo [QUEUE_DEPTH];
    int unsigned tone_head;
    int unsigned tone_tail;
    int unsigned tones_held;
    int unsigned tone_phase;
    int unsigned tone_rate;

    // Result beats still owed by the block, oldest first.
    result_t pending_beats [$];

    int max_wait      = IDLE_MAX;
    int hold_request  = 0;
    int errors        = 0;
    int beats_sent    = 0;
    int beats_checked = 0;
    int valid_samples = 0;
    int drops_seen    = 0;
    int rate_writes   = 0;

    queued_sine_tone_generator_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial clk = 1'b0;
    always #CLK_HALF clk = ~clk;

    // Horner evaluation of the quarter-wave polynomial, each product cut to Q30.
    function automatic longint unsigned q30_quarter_sine(input longint unsigned x);
        longint unsigned x2;
        longint unsigned p;
        x2 = (x * x) >> 30;
        p  = C11;
        p  = C9 - ((x2 * p) >> 30);
        p  = C7 - ((x2 * p) >> 30);
        p  = C5 - ((x2 * p) >> 30);
        p  = C3 - ((x2 * p) >> 30);
        p  = C1 - ((x2 * p) >> 30);
        return (x * p) >> 30;
    endfunction

    // Clear the mirrored state and build the full-wave Q15 sine table.
    function automatic void reset_tone_model();
        longint unsigned u;
        longint unsigned quad;
        longint unsigned x;
        longint unsigned s;
        int k;
        for (k = 0; k < SINE_TABLE_SIZE; k++) begin
            u    = 4 * k;
            quad = (u / SINE_TABLE_SIZE) & 3;
            x    = ((u % SINE_TABLE_SIZE) << 30) / SINE_TABLE_SIZE;
            if (quad & 1)
                x = Q30_UNIT - x;
            s = (q30_quarter_sine(x) + 64'd16384) >> 15;
            sine_lut[k] = (quad & 2) ? -int'(s) : int'(s);
        end
        for (k = 0; k < QUEUE_DEPTH; k++) begin
            tone_fifo[k] = '0;
        end
        tone_head  = 0;
        tone_tail  = 0;
        tones_held = 0;
        tone_phase = 0;
        tone_rate  = RATE_RESET;
    endfunction

    // Advance the mirrored state by one input beat and return the result it causes.
    function automatic result_t next_tone_output(input item_t beat);
        result_t         beat_out;
        longint unsigned count;
        longint unsigned idx;
        longint unsigned mag;
        int              entry;
        int unsigned     ph;
        beat_out = '0;
        case (beat.op)
            OP_ENQUEUE:
            begin
                count = (64'(beat.duration_ms) * 64'(tone_rate)) / MS_PER_SEC;
                if (count > COUNT_CEIL)
                    count = COUNT_CEIL;
                // A tone of zero samples is skipped without a drop.
                if (count != 0) begin
                    if (tones_held >= QUEUE_DEPTH) begin
                        beat_out.queue_drop = 1'b1;
                    end
                    else begin
                        tone_fifo[tone_tail].frequency = beat.tone_frequency;
                        tone_fifo[tone_tail].amplitude = beat.tone_amplitude;
                        tone_fifo[tone_tail].remaining = LEFT_W'(count);
                        tone_tail  = (tone_tail + 1) % QUEUE_DEPTH;
                        tones_held = tones_held + 1;
                    end
                end
            end
            OP_SAMPLE:
            begin
                if (tones_held != 0) begin
                    beat_out.sample_valid = 1'b1;
                    entry = 0;
                    // A zero rate pins the phase at zero and plays silence.
                    if (tone_rate != 0) begin
                        ph  = tone_phase % tone_rate;
                        idx = (64'(ph) * SINE_TABLE_SIZE) / tone_rate;
                        if (idx >= SINE_TABLE_SIZE)
                            idx = SINE_TABLE_SIZE - 1;
                        entry      = sine_lut[idx];
                        tone_phase = (ph + tone_fifo[tone_head].frequency) % tone_rate;
                    end
                    else begin
                        tone_phase = 0;
                    end
                    if (entry < 0) begin
                        mag = (64'(tone_fifo[tone_head].amplitude) * 64'(-entry)) >> 15;
                        beat_out.sample = SAMPLE_W'(64'h10000 - mag);
                    end
                    else begin
                        mag = (64'(tone_fifo[tone_head].amplitude) * 64'(entry)) >> 15;
                        beat_out.sample = SAMPLE_W'(mag);
                    end
                    if (tone_fifo[tone_head].remaining != 0)
                        tone_fifo[tone_head].remaining -= 1;
                    if (tone_fifo[tone_head].remaining == 0) begin
                        tone_head  = (tone_head + 1) % QUEUE_DEPTH;
                        tones_held = tones_held - 1;
                    end
                end
            end
            OP_CLEAR:
            begin
                tone_head  = 0;
                tone_tail  = 0;
                tones_held = 0;
            end
            default:
            begin
            end
        endcase
        beat_out.queue_count = COUNT_W'(tones_held);
        return beat_out;
    endfunction

    function automatic item_t tone_item(input logic [OP_W-1:0] op,
                                        input logic [FREQ_W-1:0] freq,
                                        input logic [AMP_W-1:0] amp,
                                        input logic [DUR_W-1:0] dur);
        item_t beat;
        beat.op             = op;
        beat.tone_frequency = freq;
        beat.tone_amplitude = amp;
        beat.duration_ms    = dur;
        return beat;
    endfunction

    // Offer one beat after a random gap and hold it until the block takes it.
    task automatic send_beat(input item_t beat);
        int gap;
        gap = $urandom_range(0, max_wait);
        @(negedge clk);
        if (gap > 0) begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item       <= beat;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        pending_beats.push_back(next_tone_output(beat));
        beats_sent++;
    endtask

    // Stop offering beats and wait until every owed result has come back.
    task automatic settle_beats();
        @(negedge clk);
        item_valid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // The rate register is only written once the block has gone idle.
    task automatic write_sample_rate(input logic [RATE_W-1:0] value);
        settle_beats();
        cfg_data  <= value;
        cfg_write <= 1'b1;
        @(negedge clk);
        cfg_write <= 1'b0;
        tone_rate = value;
        rate_writes++;
    endtask

    task automatic compare_field(input string field, input logic signed [63:0] want,
                                 input logic signed [63:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            errors++;
        end
    endtask

    // A request, an all-ones beat of the unused op and a clear, all on an empty queue.
    task automatic test_empty_queue();
        send_beat(tone_item(OP_SAMPLE, '0, '0, '0));
        send_beat(tone_item(OP_UNUSED, '1, '1, '1));
        send_beat(tone_item(OP_CLEAR, '0, '0, '0));
    endtask

    // A saturated long tone, then fill the queue to the brim and overflow it.
    task automatic test_long_tone_and_full_queue();
        int k;
        write_sample_rate('1);
        send_beat(tone_item(OP_ENQUEUE, '1, '1, '1));
        send_beat(tone_item(OP_SAMPLE, '0, '0, '0));
        for (k = 1; k < QUEUE_DEPTH; k++) begin
            send_beat(tone_item(OP_ENQUEUE, (k % 2) ? FREQ_W'(24000) : FREQ_W'(0),
                                (k % 3) ? AMP_W'($urandom) : AMP_W'(0), DUR_W'(1)));
        end
        send_beat(tone_item(OP_ENQUEUE, FREQ_W'(440), AMP_W'(1000), DUR_W'(1)));
        send_beat(tone_item(OP_CLEAR, '0, '0, '0));
    endtask

    // Lowering the rate below the running phase makes the next request wrap it first.
    task automatic test_phase_above_rate();
        write_sample_rate(16'd8000);
        send_beat(tone_item(OP_ENQUEUE, FREQ_W'(1000), '1, DUR_W'(1)));
        send_beat(tone_item(OP_SAMPLE, '0, '0, '0));
        send_beat(tone_item(OP_SAMPLE, '0, '0, '0));
    endtask

    // With a zero rate a queued tone plays silence and new tones have no length.
    task automatic test_zero_rate();
        write_sample_rate('0);
        send_beat(tone_item(OP_SAMPLE, '0, '0, '0));
        send_beat(tone_item(OP_ENQUEUE, FREQ_W'(100), AMP_W'(100), '1));
        send_beat(tone_item(OP_CLEAR, '0, '0, '0));
    endtask

    // The output side holds off for a long stretch while requests keep coming.
    task automatic test_output_backpressure();
        int k;
        write_sample_rate(16'd2000);
        max_wait = 0;
        send_beat(tone_item(OP_ENQUEUE, FREQ_W'(300), AMP_W'(20000), DUR_W'(100)));
        hold_request = LONG_HOLD;
        for (k = 0; k < 10; k++) begin
            send_beat(tone_item(OP_SAMPLE, '0, '0, '0));
        end
        max_wait = IDLE_MAX;
    endtask

    // Mostly short tone bursts followed by runs of requests, plus clears and noise.
    task automatic run_random_tones(input logic [RATE_W-1:0] rate, input int beats,
                                    input int idle_max);
        int                sent;
        int                pick;
        int                burst;
        int                k;
        logic [63:0]       noise;
        logic [FREQ_W-1:0] freq;
        logic [DUR_W-1:0]  dur;
        write_sample_rate(rate);
        max_wait = idle_max;
        sent = 0;
        while (sent < beats) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                burst = $urandom_range(1, 3);
                for (k = 0; k < burst; k++) begin
                    freq = ($urandom_range(0, 3) == 0) ? FREQ_W'($urandom)
                                                       : FREQ_W'($urandom_range(0, 24000));
                    dur  = ($urandom_range(0, 9) == 0) ? DUR_W'($urandom)
                                                       : DUR_W'($urandom_range(0, 3));
                    send_beat(tone_item(OP_ENQUEUE, freq, AMP_W'($urandom), dur));
                end
                sent += burst;
                burst = $urandom_range(1, 14);
                for (k = 0; k < burst; k++) begin
                    send_beat(tone_item(OP_SAMPLE, FREQ_W'($urandom), AMP_W'($urandom),
                                        DUR_W'($urandom)));
                end
                sent += burst;
            end
            else if (pick < 78) begin
                send_beat(tone_item(OP_CLEAR, FREQ_W'($urandom), AMP_W'($urandom),
                                    DUR_W'($urandom)));
                sent++;
            end
            else begin
                noise = {$urandom, $urandom};
                send_beat(item_t'(noise[$bits(item_t)-1:0]));
                sent++;
            end
        end
        max_wait = IDLE_MAX;
    endtask

    // Check every result beat against the oldest owed one and pace the output side.
    initial begin : result_sink
        int      stall_left;
        int      hold_left;
        result_t want;
        stall_left   = 0;
        hold_left    = 0;
        result_stall = 1'b0;
        forever begin
            @(posedge clk);
            if (result_valid && !result_stall) begin
                if (pending_beats.size() == 0) begin
                    $display("%0t ns: result beat with nothing owed, actual %h", $time, result);
                    errors++;
                end
                else begin
                    want = pending_beats[0];
                    pending_beats.delete(0);
                    compare_field("sample", want.sample, result.sample);
                    compare_field("sample_valid", want.sample_valid, result.sample_valid);
                    compare_field("queue_drop", want.queue_drop, result.queue_drop);
                    compare_field("queue_count", want.queue_count, result.queue_count);
                    if (want.sample_valid)
                        valid_samples++;
                    if (want.queue_drop)
                        drops_seen++;
                end
                beats_checked++;
                stall_left = $urandom_range(0, max_wait);
            end
            @(negedge clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (stall_left > 0) begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else begin
                result_stall <= 1'b0;
            end
        end
    end

    // End the run when no beat has moved on either side for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t ns: no beat moved for %0d cycles", $time, IDLE_LIMIT);
        $display("queued_sine_tone_generator_core verification failed");
        $finish;
    end

    // Reset, directed cases, back-pressure, then random phases at several rates.
    initial begin : stimulus
        rst_n      = 1'b0;
        cfg_write  = 1'b0;
        cfg_data   = '0;
        item_valid = 1'b0;
        item       = '0;
        reset_tone_model();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_queue();
        test_long_tone_and_full_queue();
        test_phase_above_rate();
        test_zero_rate();
        test_output_backpressure();

        run_random_tones(16'd8000, 100, IDLE_MAX);
        run_random_tones(16'd1000, 100, 0);
        run_random_tones(16'd48000, 100, IDLE_MAX);
        run_random_tones(RATE_W'($urandom_range(8000, 48000)), 100, IDLE_MAX);
        run_random_tones(16'd2500, 100, 3);

        settle_beats();
        $display("Run covered %0d item beats and %0d result beats over %0d rate settings,",
                 beats_sent, beats_checked, rate_writes);
        $display("with %0d tone samples played and %0d enqueues dropped on a full queue.",
                 valid_samples, drops_seen);
        if (errors == 0 && pending_beats.size() == 0) begin
            $display("queued_sine_tone_generator_core verification clean");
        end
        else begin
            $display("queued_sine_tone_generator_core verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/qstg_pkg.sv
src/qstg_divider.sv
src/qstg_datapath.sv
src/qstg_ctrl.sv
src/queued_sine_tone_generator_core.sv
verif/tb_queued_sine_tone_generator_core.sv
